/* sv/vtm_pkg.sv */
// Shared types, constants and tables for the video transition mixer.
package vtm_pkg;

  // Transition position is Q1.16: T_ONE means fully the second source.
  localparam logic [16:0] T_ONE  = 17'd65536;
  localparam logic [16:0] T_LOW  = 17'd66;
  localparam logic [16:0] T_HIGH = 17'd65470;

  // Frame dimensions as held in the configuration registers.
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned DIM_MAX_REG = 8191;

  // Reciprocal table scaling for division by the pass count.
  localparam int unsigned RCP_SHIFT = 23;
  localparam int unsigned RCP_W     = 24;

  // Cycles from a configuration change until the wipe geometry is settled.
  localparam logic [2:0] GEO_LAT = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_POSITION    = 3'd1;
  localparam logic [2:0] REG_ORIENTATION = 3'd2;
  localparam logic [2:0] REG_PASS_COUNT  = 3'd3;
  localparam logic [2:0] REG_BOTTOM_SEC  = 3'd4;
  localparam logic [2:0] REG_FRAME_W     = 3'd5;
  localparam logic [2:0] REG_FRAME_H     = 3'd6;

  // Mixing modes.
  localparam logic MODE_BLEND = 1'b0;
  localparam logic MODE_WIPE  = 1'b1;

  // Geometry of the wipe, expressed along the stripe axis (major) and the
  // axis along which the partial stripe grows (minor).
  typedef struct packed {
    logic             ready;
    logic             t_low;
    logic             t_high;
    logic [16:0]      t;
    logic [DIM_W-1:0] minor_dim;
    logic [DIM_W-1:0] whole_len;
    logic [DIM_W-1:0] frac_len;
    logic [DIM_W:0]   stripe_end;
  } geom_t;

  // ceil(2^23 / n) for n = 1..31; a zero count is treated as one pass.
  function automatic logic [RCP_W-1:0] recip_q23(input logic [4:0] n);
    logic [RCP_W-1:0] r;
    case (n)
      5'd2:    r = 24'd4194304;
      5'd3:    r = 24'd2796203;
      5'd4:    r = 24'd2097152;
      5'd5:    r = 24'd1677722;
      5'd6:    r = 24'd1398102;
      5'd7:    r = 24'd1198373;
      5'd8:    r = 24'd1048576;
      5'd9:    r = 24'd932068;
      5'd10:   r = 24'd838861;
      5'd11:   r = 24'd762601;
      5'd12:   r = 24'd699051;
      5'd13:   r = 24'd645278;
      5'd14:   r = 24'd599187;
      5'd15:   r = 24'd559241;
      5'd16:   r = 24'd524288;
      5'd17:   r = 24'd493448;
      5'd18:   r = 24'd466034;
      5'd19:   r = 24'd441506;
      5'd20:   r = 24'd419431;
      5'd21:   r = 24'd399458;
      5'd22:   r = 24'd381301;
      5'd23:   r = 24'd364723;
      5'd24:   r = 24'd349526;
      5'd25:   r = 24'd335545;
      5'd26:   r = 24'd322639;
      5'd27:   r = 24'd310690;
      5'd28:   r = 24'd299594;
      5'd29:   r = 24'd289263;
      5'd30:   r = 24'd279621;
      5'd31:   r = 24'd270601;
      default: r = 24'd8388608;
    endcase
    return r;
  endfunction

endpackage

/* sv/video_transition_mixer.sv */
// Top level of the per-pixel transition mixer between two RGB sources.
//
// Pixels enter on the in_ channel (first and second source pixel plus the
// pixel's column and row) and leave on the out_ channel as one mixed RGB
// pixel per request, in order. Both channels use a valid/ready handshake.
// The path is an input register, one stage of blend and wipe logic, and an
// output register, so each result passes through the input register and then
// the output register; one request is taken every cycle while the receiver
// keeps up and the geometry is settled. When the receiver stalls, the output
// register holds its result and the input register can still take one more
// request; after that in_ready drops until the output drains.
// The wipe rectangles depend on the configuration only and are worked out by
// a four-stage pipeline (multiply, multiply, reciprocal divide by the pass
// count, add). After reset and after every write on the configuration port,
// in_ready stays low while that pipeline settles. Reset (synchronous, active
// low) restores the register defaults and empties both pipeline registers.
module video_transition_mixer #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_first_pixel,
  input  logic [23:0] in_second_pixel,
  input  logic [11:0] in_pixel_x,
  input  logic [11:0] in_pixel_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_mixed_pixel,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vtm_pkg::*;

  // Configuration registers.
  logic             mode_r;
  logic [16:0]      position_r;
  logic             orientation_r;
  logic [4:0]       pass_count_r;
  logic             bottom_is_second_r;
  logic [DIM_W-1:0] img_width_r, img_height_r;

  logic [2:0] reg_idx;
  logic       wr_en;
  geom_t      geom;

  // Pixel pipeline.
  logic        s1_v_r, s1_v_nxt;
  logic [23:0] s1_first_r, s1_second_r;
  logic [11:0] s1_x_r, s1_y_r;
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_pixel_r;
  logic        in_accept, s1_move;

  logic [23:0] blend_pix, wipe_pix, top_pix, bottom_pix, mix_pix;
  logic [13:0] major_c, minor_c;
  logic        covered;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r             <= MODE_BLEND;
      position_r         <= 17'd0;
      orientation_r      <= 1'b1;
      pass_count_r       <= 5'd8;
      bottom_is_second_r <= 1'b0;
      img_width_r        <= 13'd640;
      img_height_r       <= 13'd480;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODE:        mode_r             <= pwdata[0];
        REG_POSITION:    position_r         <= pwdata[16:0];
        REG_ORIENTATION: orientation_r      <= pwdata[0];
        REG_PASS_COUNT:  pass_count_r       <= pwdata[4:0];
        REG_BOTTOM_SEC:  bottom_is_second_r <= pwdata[0];
        REG_FRAME_W:     img_width_r        <= pwdata[DIM_W-1:0];
        REG_FRAME_H:     img_height_r       <= pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:        prdata = {31'b0, mode_r};
      REG_POSITION:    prdata = {15'b0, position_r};
      REG_ORIENTATION: prdata = {31'b0, orientation_r};
      REG_PASS_COUNT:  prdata = {27'b0, pass_count_r};
      REG_BOTTOM_SEC:  prdata = {31'b0, bottom_is_second_r};
      REG_FRAME_W:     prdata = {{(32-DIM_W){1'b0}}, img_width_r};
      REG_FRAME_H:     prdata = {{(32-DIM_W){1'b0}}, img_height_r};
      default:         prdata = 32'd0;
    endcase
  end

  // Any write restarts the geometry pipeline, whichever register it hits.
  vtm_geom #(
    .MAX_DIM (MAX_DIM)
  ) u_geom (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (wr_en),
    .position     (position_r),
    .orientation  (orientation_r),
    .pass_count   (pass_count_r),
    .img_width    (img_width_r),
    .img_height   (img_height_r),
    .geom         (geom)
  );

  // Handshake: the input register moves on whenever the output register is
  // empty or being drained in the same cycle.
  assign s1_move   = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready  = geom.ready && (!s1_v_r || s1_move);
  assign in_accept = in_valid && in_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_move) begin
      s1_v_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_first_r  <= in_first_pixel;
      s1_second_r <= in_second_pixel;
      s1_x_r      <= in_pixel_x;
      s1_y_r      <= in_pixel_y;
    end
    if (s1_move) begin
      out_pixel_r <= mix_pix;
    end
  end

  // Crossfade: a*(1-T) + b*T is rewritten as a + (b-a)*T, one signed
  // multiply per color channel, floored by the arithmetic shift.
  genvar ch;
  generate
    for (ch = 0; ch < 3; ch++) begin : g_lane
      logic signed [8:0]  diff;
      logic signed [26:0] prod;
      logic        [10:0] sum;
      always_comb begin
        diff = $signed({1'b0, s1_second_r[8*ch +: 8]}) -
               $signed({1'b0, s1_first_r[8*ch +: 8]});
        prod = diff * $signed({1'b0, geom.t});
        sum  = prod[26:16] + {3'b000, s1_first_r[8*ch +: 8]};
      end
      assign blend_pix[8*ch +: 8] = sum[7:0];
    end
  endgenerate

  // Wipe: along the stripe axis the whole stripes cover [0, whole_len) across
  // the full frame; the partial stripe covers [whole_len, stripe_end) along
  // that axis and [0, frac_len) across it.
  always_comb begin
    major_c = orientation_r ? {2'b00, s1_x_r} : {2'b00, s1_y_r};
    minor_c = orientation_r ? {2'b00, s1_y_r} : {2'b00, s1_x_r};
    covered = ((minor_c < {1'b0, geom.minor_dim}) &&
               (major_c < {1'b0, geom.whole_len})) ||
              ((minor_c < {1'b0, geom.frac_len}) &&
               (major_c >= {1'b0, geom.whole_len}) &&
               (major_c < geom.stripe_end));
    bottom_pix = bottom_is_second_r ? s1_second_r : s1_first_r;
    top_pix    = bottom_is_second_r ? s1_first_r : s1_second_r;
    if (geom.t_low) begin
      wipe_pix = bottom_pix;
    end else if (geom.t_high) begin
      wipe_pix = top_pix;
    end else begin
      wipe_pix = covered ? top_pix : bottom_pix;
    end
  end

  always_comb begin
    if (mode_r == MODE_WIPE) begin
      mix_pix = wipe_pix;
    end else if (geom.t_low) begin
      mix_pix = s1_first_r;
    end else if (geom.t_high) begin
      mix_pix = s1_second_r;
    end else begin
      mix_pix = blend_pix;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mixed_pixel = out_pixel_r;

  a_write_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> !in_ready)
    else $error("request accepted while wipe geometry was settling");

  a_stall_keeps_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_valid_r && !out_ready) |=> (s1_v_r && out_valid_r))
    else $error("pipeline lost a request during an output stall");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_v_r)
    else $error("accepted request did not reach the input register");

  a_blend_start_passes_first: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && mode_r == MODE_BLEND && geom.t_low) |=>
      (out_pixel_r == $past(s1_first_r)))
    else $error("start of crossfade did not pass the first source");

endmodule

/* sv/vtm_geom.sv */
// Four-stage pipeline that derives the wipe rectangles from the configuration.
module vtm_geom #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        restart,
  input  logic [16:0]                 position,
  input  logic                        orientation,
  input  logic [4:0]                  pass_count,
  input  logic [vtm_pkg::DIM_W-1:0]   img_width,
  input  logic [vtm_pkg::DIM_W-1:0]   img_height,
  output vtm_pkg::geom_t              geom
);
  import vtm_pkg::*;

  localparam int unsigned DIM_CAP = (MAX_DIM > DIM_MAX_REG) ? DIM_MAX_REG : MAX_DIM;
  localparam logic [DIM_W-1:0] DIM_CAP_V = DIM_W'(DIM_CAP);

  logic [DIM_W-1:0] w, h, major, minor;
  logic [4:0]       n;
  logic [16:0]      t_sat;
  logic [21:0]      p;
  logic [17:0]      num;
  logic [28:0]      frac_prod;
  logic [RCP_W-1:0] rcp;
  logic [41:0]      q_whole;
  logic [36:0]      q_stripe;

  logic [2:0]       cnt_r, cnt_nxt;
  logic [16:0]      a_t_r;
  logic             a_low_r, a_high_r;
  logic [4:0]       a_whole_r;
  logic [15:0]      a_frac_r;
  logic [17:0]      b_num_r;
  logic [DIM_W-1:0] b_frac_len_r;
  logic [DIM_W-1:0] c_whole_len_r, c_stripe_r, c_frac_len_r;
  geom_t            geom_r;

  // The configuration is stable while the pipeline settles, so every stage
  // reads the clamped values directly.
  always_comb begin
    w      = (img_width > DIM_CAP_V) ? DIM_CAP_V : img_width;
    h      = (img_height > DIM_CAP_V) ? DIM_CAP_V : img_height;
    n      = (pass_count == 5'd0) ? 5'd1 : pass_count;
    major  = orientation ? w : h;
    minor  = orientation ? h : w;
    t_sat  = (position > T_ONE) ? T_ONE : position;
    p         = {5'b0, t_sat} * {17'b0, n};
    num       = ({5'b0, major} * {13'b0, a_whole_r}) + {13'b0, n} - 18'd1;
    frac_prod = {16'b0, minor} * {13'b0, a_frac_r};
    rcp       = recip_q23(n);
    q_whole   = {24'b0, b_num_r} * {18'b0, rcp};
    q_stripe  = {24'b0, major} * {13'b0, rcp};
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (restart) begin
      cnt_nxt = GEO_LAT;
    end else if (cnt_r != 3'd0) begin
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= GEO_LAT;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_t_r     <= t_sat;
    a_low_r   <= (t_sat <= T_LOW);
    a_high_r  <= (t_sat >= T_HIGH);
    a_whole_r <= p[20:16];
    a_frac_r  <= p[15:0];

    b_num_r      <= num;
    b_frac_len_r <= frac_prod[28:16];

    c_whole_len_r <= q_whole[RCP_SHIFT+DIM_W-1:RCP_SHIFT];
    c_stripe_r    <= q_stripe[RCP_SHIFT+DIM_W-1:RCP_SHIFT];
    c_frac_len_r  <= b_frac_len_r;

    // Ready follows the settle counter reaching zero; reset clears it.
    geom_r.ready      <= rst_n && (cnt_nxt == 3'd0);
    geom_r.t          <= a_t_r;
    geom_r.t_low      <= a_low_r;
    geom_r.t_high     <= a_high_r;
    geom_r.minor_dim  <= minor;
    geom_r.whole_len  <= c_whole_len_r;
    geom_r.frac_len   <= c_frac_len_r;
    geom_r.stripe_end <= {1'b0, c_whole_len_r} + {1'b0, c_stripe_r};
  end

  assign geom = geom_r;

  a_restart_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> !geom.ready)
    else $error("geometry reported ready right after a restart");

  a_ready_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (geom.ready && !restart) |=> geom.ready)
    else $error("geometry ready dropped without a restart");

  a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (!restart && cnt_r != 3'd0) |=> (cnt_r == $past(cnt_r) - 3'd1))
    else $error("geometry settle counter did not step down");

endmodule
